// ----- rtl/core/adt_pkg.sv -----
package adt_pkg;

   localparam int DW              = 40;
   localparam int RW              = 18;
   localparam int DIV_SHORT       = 17;
   localparam int MAX_RESULTS_DEF = 64;

   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 4;

   localparam logic [1:0] KIND_FLOW   = 2'd0;
   localparam logic [1:0] KIND_ANTI   = 2'd1;
   localparam logic [1:0] KIND_OUTPUT = 2'd2;

   localparam logic CSR_LOOP_START = 1'b0;
   localparam logic CSR_LOOP_END   = 1'b1;

   localparam logic [1:0] BND_SRC   = 2'd0;
   localparam logic [1:0] BND_DST   = 2'd1;
   localparam logic [1:0] BND_ORDER = 2'd2;

   localparam logic [4:0] OP_NOP        = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_EU_DIV     = 5'd2;
   localparam logic [4:0] OP_EU_UPD     = 5'd3;
   localparam logic [4:0] OP_CC_DIV     = 5'd4;
   localparam logic [4:0] OP_CC_SAVE    = 5'd5;
   localparam logic [4:0] OP_S1_DIV     = 5'd6;
   localparam logic [4:0] OP_S1_SAVE    = 5'd7;
   localparam logic [4:0] OP_S2_DIV     = 5'd8;
   localparam logic [4:0] OP_S2_SAVE    = 5'd9;
   localparam logic [4:0] OP_MUL        = 5'd10;
   localparam logic [4:0] OP_BND_ZERO   = 5'd11;
   localparam logic [4:0] OP_BLO_DIV    = 5'd12;
   localparam logic [4:0] OP_BLO_SAVE   = 5'd13;
   localparam logic [4:0] OP_BHI_DIV    = 5'd14;
   localparam logic [4:0] OP_BHI_SAVE   = 5'd15;
   localparam logic [4:0] OP_START      = 5'd16;
   localparam logic [4:0] OP_EMIT       = 5'd17;
   localparam logic [4:0] OP_EMIT_NONE  = 5'd18;
   localparam logic [4:0] OP_EMIT_CONST = 5'd19;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] bnd;
   } cmd_type;

   typedef struct packed {
      logic kind_none;
      logic rb_zero;
      logic g_zero;
      logic d_equal;
      logic div_done;
      logic rem_nz;
      logic s_zero;
      logic no_dep;
      logic emit_last;
      logic rsp_free;
   } stat_type;

endpackage

// ----- rtl/core/adt_div.sv -----
module adt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            short_mode,
   input  logic signed [adt_pkg::DW-1:0]   num,
   input  logic signed [adt_pkg::DW-1:0]   den,
   output logic                            busy,
   output logic                            done,
   output logic signed [adt_pkg::DW-1:0]   quo,
   output logic signed [adt_pkg::DW-1:0]   rem
);
   localparam int W    = adt_pkg::DW;
   localparam int CNTW = $clog2(W + 1);

   logic            busy_ff, done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [W-1:0]    a_ff, rem_ff, quo_ff, dvs_ff;
   logic            negq_ff, negr_ff;
   logic [W-1:0]    num_mag, den_mag, trial;
   logic            ge;

   assign num_mag = num[W-1] ? -num : num;
   assign den_mag = den[W-1] ? -den : den;
   assign trial   = {rem_ff[W-2:0], a_ff[W-1]};
   assign ge      = trial >= dvs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= short_mode ? CNTW'(adt_pkg::DIV_SHORT) : CNTW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= short_mode ? (num_mag << (W - adt_pkg::DIV_SHORT)) : num_mag;
         rem_ff  <= '0;
         quo_ff  <= '0;
         dvs_ff  <= den_mag;
         negq_ff <= num[W-1] ^ den[W-1];
         negr_ff <= num[W-1];
      end else if (busy_ff) begin
         a_ff   <= a_ff << 1;
         rem_ff <= ge ? trial - dvs_ff : trial;
         quo_ff <= {quo_ff[W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = negq_ff ? -quo_ff : quo_ff;
   assign rem  = negr_ff ? -rem_ff : rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

endmodule

// ----- rtl/core/adt_datapath.sv -----
module adt_datapath #(
   parameter int MAX_RESULTS = adt_pkg::MAX_RESULTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  adt_pkg::cmd_type                    cmd,
   output adt_pkg::stat_type                   stat,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [15:0]                         csr_data,
   input  logic [adt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [adt_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [adt_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [adt_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);
   localparam int W  = adt_pkg::DW;
   localparam int RW = adt_pkg::RW;
   localparam int CW = $clog2(MAX_RESULTS + 1);
   localparam logic signed [W-1:0] LIM = W'(MAX_RESULTS - 1);

   logic signed [15:0]   ls_ff, le_ff;
   logic [1:0]           kind_ff;
   logic                 none_ff;
   logic [7:0]           ss_ff, ds_ff;
   logic signed [15:0]   d1_ff, d2_ff;
   logic signed [RW-1:0] na_ff, b_ff, cc_ff, ra_ff, rb_ff;
   logic signed [RW-1:0] x0_ff, x1_ff, y0_ff, y1_ff, h_ff, s1_ff, s2_ff;
   logic signed [W-1:0]  i1_ff, i2_ff, tlo_ff, thi_ff;
   logic                 empty_ff;
   logic [15:0]          v1_ff, v2_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 trunc_ff;

   logic                 rsp_valid_ff, rsp_has_ff, rsp_last_ff, rsp_trunc_ff;
   logic [1:0]           rsp_kind_ff;
   logic [7:0]           rsp_ss_ff, rsp_ds_ff;
   logic [15:0]          rsp_i1_ff, rsp_i2_ff;

   logic                 src_st, dst_st, same;
   logic signed [15:0]   c1, k1, c2, k2;
   logic [1:0]           kind_in;

   logic signed [W-1:0]  lo_w, bs, bc, bhi, rmin, rmax;
   logic                 in_range, rsp_free;

   logic                 div_start, div_short, div_busy, div_done;
   logic signed [W-1:0]  div_num, div_den, dq, dr;
   logic                 rnz;
   logic signed [W-1:0]  q_floor, q_ceil;

   logic signed [RW-1:0]   qn;
   logic signed [2*RW-1:0] qx, qy, px, py;
   logic signed [W-1:0]    diff;
   logic                   emit_op;

   assign src_st = req_tuser[0];
   assign dst_st = req_tuser[1];
   assign same   = req_tuser[2];
   assign c1     = req_tdata[15:0];
   assign k1     = req_tdata[31:16];
   assign c2     = req_tdata[47:32];
   assign k2     = req_tdata[63:48];

   always_comb begin
      if (src_st && !dst_st) begin
         kind_in = adt_pkg::KIND_FLOW;
      end else if (!src_st && dst_st) begin
         kind_in = adt_pkg::KIND_ANTI;
      end else if (src_st && dst_st) begin
         kind_in = adt_pkg::KIND_OUTPUT;
      end else begin
         kind_in = adt_pkg::KIND_FLOW;
      end
   end

   assign lo_w = W'(ls_ff);

   always_comb begin
      case (cmd.bnd)
         adt_pkg::BND_SRC: begin
            bs  = W'(s1_ff);
            bc  = i1_ff;
            bhi = W'(le_ff);
         end
         adt_pkg::BND_DST: begin
            bs  = W'(s2_ff);
            bc  = i2_ff;
            bhi = W'(le_ff);
         end
         default: begin
            bs  = W'(s1_ff) - W'(s2_ff);
            bc  = '0;
            bhi = i2_ff - i1_ff + W'(ss_ff < ds_ff);
         end
      endcase
   end

   assign rmin     = lo_w - bc;
   assign rmax     = bhi - bc - W'(1);
   assign in_range = (cmd.bnd == adt_pkg::BND_ORDER || lo_w <= bc) && bc < bhi;

   always_comb begin
      div_start = 1'b1;
      div_short = 1'b1;
      div_num   = W'(ra_ff);
      div_den   = W'(rb_ff);
      case (cmd.op)
         adt_pkg::OP_EU_DIV: begin
            div_num = W'(ra_ff);
            div_den = W'(rb_ff);
         end
         adt_pkg::OP_CC_DIV: begin
            div_num = W'(cc_ff);
            div_den = W'(ra_ff);
         end
         adt_pkg::OP_S1_DIV: begin
            div_num = W'(b_ff);
            div_den = W'(ra_ff);
         end
         adt_pkg::OP_S2_DIV: begin
            div_num = W'(na_ff);
            div_den = W'(ra_ff);
         end
         adt_pkg::OP_BLO_DIV: begin
            div_short = 1'b0;
            div_num   = rmin;
            div_den   = bs;
         end
         adt_pkg::OP_BHI_DIV: begin
            div_short = 1'b0;
            div_num   = rmax;
            div_den   = bs;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   adt_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .short_mode (div_short),
      .num        (div_num),
      .den        (div_den),
      .busy       (div_busy),
      .done       (div_done),
      .quo        (dq),
      .rem        (dr)
   );

   assign rnz     = dr != '0;
   assign q_floor = dq - W'(rnz && (dr[W-1] != bs[W-1]));
   assign q_ceil  = dq + W'(rnz && (dr[W-1] == bs[W-1]));

   assign qn   = dq[RW-1:0];
   assign qx   = qn * x1_ff;
   assign qy   = qn * y1_ff;
   assign px   = x0_ff * h_ff;
   assign py   = y0_ff * h_ff;
   assign diff = thi_ff - tlo_ff;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign emit_op  = cmd.op == adt_pkg::OP_EMIT || cmd.op == adt_pkg::OP_EMIT_NONE
                     || cmd.op == adt_pkg::OP_EMIT_CONST;

   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff <= '0;
         le_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == adt_pkg::CSR_LOOP_START) begin
            ls_ff <= csr_data;
         end else begin
            le_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         adt_pkg::OP_LOAD: begin
            kind_ff  <= kind_in;
            none_ff  <= !(src_st || dst_st) || !same;
            ss_ff    <= req_tdata[71:64];
            ds_ff    <= req_tdata[79:72];
            d1_ff    <= k1;
            d2_ff    <= k2;
            na_ff    <= -RW'(c1);
            b_ff     <= -RW'(c2);
            cc_ff    <= RW'(k2) - RW'(k1);
            ra_ff    <= RW'(c1);
            rb_ff    <= -RW'(c2);
            x0_ff    <= RW'(1);
            x1_ff    <= '0;
            y0_ff    <= '0;
            y1_ff    <= RW'(1);
            tlo_ff   <= {1'b1, {(W-1){1'b0}}};
            thi_ff   <= {1'b0, {(W-1){1'b1}}};
            empty_ff <= 1'b0;
         end
         adt_pkg::OP_EU_UPD: begin
            ra_ff <= rb_ff;
            rb_ff <= dr[RW-1:0];
            x0_ff <= x1_ff;
            x1_ff <= x0_ff - qx[RW-1:0];
            y0_ff <= y1_ff;
            y1_ff <= y0_ff - qy[RW-1:0];
         end
         adt_pkg::OP_CC_SAVE: begin
            h_ff <= dq[RW-1:0];
         end
         adt_pkg::OP_S1_SAVE: begin
            s1_ff <= dq[RW-1:0];
         end
         adt_pkg::OP_S2_SAVE: begin
            s2_ff <= dq[RW-1:0];
         end
         adt_pkg::OP_MUL: begin
            i1_ff <= W'(px);
            i2_ff <= W'(py);
         end
         adt_pkg::OP_BND_ZERO: begin
            if (!in_range) begin
               empty_ff <= 1'b1;
            end
         end
         adt_pkg::OP_BLO_SAVE: begin
            if (!bs[W-1]) begin
               if (q_ceil > tlo_ff) begin
                  tlo_ff <= q_ceil;
               end
            end else if (q_floor < thi_ff) begin
               thi_ff <= q_floor;
            end
         end
         adt_pkg::OP_BHI_SAVE: begin
            if (!bs[W-1]) begin
               if (q_floor < thi_ff) begin
                  thi_ff <= q_floor;
               end
            end else if (q_ceil > tlo_ff) begin
               tlo_ff <= q_ceil;
            end
         end
         adt_pkg::OP_START: begin
            v1_ff    <= i1_ff[15:0] + 16'(tlo_ff[15:0] * s1_ff[15:0]);
            v2_ff    <= i2_ff[15:0] + 16'(tlo_ff[15:0] * s2_ff[15:0]);
            cnt_ff   <= (diff >= LIM) ? LIM[CW-1:0] : diff[CW-1:0];
            trunc_ff <= diff > LIM;
         end
         adt_pkg::OP_EMIT: begin
            v1_ff  <= v1_ff + s1_ff[15:0];
            v2_ff  <= v2_ff + s2_ff[15:0];
            cnt_ff <= cnt_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_op) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_op) begin
         rsp_kind_ff <= kind_ff;
         rsp_ss_ff   <= ss_ff;
         rsp_ds_ff   <= ds_ff;
      end
      case (cmd.op)
         adt_pkg::OP_EMIT: begin
            rsp_has_ff   <= 1'b1;
            rsp_i1_ff    <= v1_ff;
            rsp_i2_ff    <= v2_ff;
            rsp_last_ff  <= cnt_ff == '0;
            rsp_trunc_ff <= (cnt_ff == '0) && trunc_ff;
         end
         adt_pkg::OP_EMIT_NONE: begin
            rsp_has_ff   <= 1'b0;
            rsp_i1_ff    <= '0;
            rsp_i2_ff    <= '0;
            rsp_last_ff  <= 1'b1;
            rsp_trunc_ff <= 1'b0;
         end
         adt_pkg::OP_EMIT_CONST: begin
            rsp_has_ff   <= 1'b1;
            rsp_i1_ff    <= d1_ff;
            rsp_i2_ff    <= d2_ff;
            rsp_last_ff  <= 1'b1;
            rsp_trunc_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign stat.kind_none = none_ff;
   assign stat.rb_zero   = rb_ff == '0;
   assign stat.g_zero    = ra_ff == '0;
   assign stat.d_equal   = d1_ff == d2_ff;
   assign stat.div_done  = div_done;
   assign stat.rem_nz    = rnz;
   assign stat.s_zero    = bs == '0;
   assign stat.no_dep    = empty_ff || (tlo_ff > thi_ff);
   assign stat.emit_last = cnt_ff == '0;
   assign stat.rsp_free  = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_i2_ff, rsp_i1_ff, rsp_ds_ff, rsp_ss_ff};
   assign rsp_tuser  = {rsp_trunc_ff, rsp_kind_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == adt_pkg::OP_EU_DIV || cmd.op == adt_pkg::OP_BLO_DIV
       || cmd.op == adt_pkg::OP_BHI_DIV) |-> (div_den != '0 && !div_busy))
      else $error("division issued with zero divisor or busy unit");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_op |-> rsp_free)
      else $error("result beat overwritten");

endmodule

// ----- rtl/core/adt_ctrl.sv -----
module adt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  adt_pkg::stat_type stat,
   output adt_pkg::cmd_type  cmd
);
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_CLASS    = 5'd1;
   localparam logic [4:0] S_EU_TEST  = 5'd2;
   localparam logic [4:0] S_EU_WAIT  = 5'd3;
   localparam logic [4:0] S_G        = 5'd4;
   localparam logic [4:0] S_CC_WAIT  = 5'd5;
   localparam logic [4:0] S_S1_DIV   = 5'd6;
   localparam logic [4:0] S_S1_WAIT  = 5'd7;
   localparam logic [4:0] S_S2_DIV   = 5'd8;
   localparam logic [4:0] S_S2_WAIT  = 5'd9;
   localparam logic [4:0] S_MUL      = 5'd10;
   localparam logic [4:0] S_BSEL     = 5'd11;
   localparam logic [4:0] S_BLO_DIV  = 5'd12;
   localparam logic [4:0] S_BLO_WAIT = 5'd13;
   localparam logic [4:0] S_BHI_DIV  = 5'd14;
   localparam logic [4:0] S_BHI_WAIT = 5'd15;
   localparam logic [4:0] S_PREP     = 5'd16;
   localparam logic [4:0] S_EMIT     = 5'd17;
   localparam logic [4:0] S_NONE     = 5'd18;
   localparam logic [4:0] S_CONST    = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [1:0] bnd_ff, bnd_in;
   logic [4:0] op;

   always_comb begin
      state_in = state_ff;
      bnd_in   = bnd_ff;
      op       = adt_pkg::OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op       = adt_pkg::OP_LOAD;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            state_in = stat.kind_none ? S_NONE : S_EU_TEST;
         end
         S_EU_TEST: begin
            if (stat.rb_zero) begin
               state_in = S_G;
            end else begin
               op       = adt_pkg::OP_EU_DIV;
               state_in = S_EU_WAIT;
            end
         end
         S_EU_WAIT: begin
            if (stat.div_done) begin
               op       = adt_pkg::OP_EU_UPD;
               state_in = S_EU_TEST;
            end
         end
         S_G: begin
            if (stat.g_zero) begin
               state_in = stat.d_equal ? S_CONST : S_NONE;
            end else begin
               op       = adt_pkg::OP_CC_DIV;
               state_in = S_CC_WAIT;
            end
         end
         S_CC_WAIT: begin
            if (stat.div_done) begin
               if (stat.rem_nz) begin
                  state_in = S_NONE;
               end else begin
                  op       = adt_pkg::OP_CC_SAVE;
                  state_in = S_S1_DIV;
               end
            end
         end
         S_S1_DIV: begin
            op       = adt_pkg::OP_S1_DIV;
            state_in = S_S1_WAIT;
         end
         S_S1_WAIT: begin
            if (stat.div_done) begin
               op       = adt_pkg::OP_S1_SAVE;
               state_in = S_S2_DIV;
            end
         end
         S_S2_DIV: begin
            op       = adt_pkg::OP_S2_DIV;
            state_in = S_S2_WAIT;
         end
         S_S2_WAIT: begin
            if (stat.div_done) begin
               op       = adt_pkg::OP_S2_SAVE;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            op       = adt_pkg::OP_MUL;
            bnd_in   = adt_pkg::BND_SRC;
            state_in = S_BSEL;
         end
         S_BSEL: begin
            if (stat.s_zero) begin
               op = adt_pkg::OP_BND_ZERO;
               if (bnd_ff == adt_pkg::BND_ORDER) begin
                  state_in = S_PREP;
               end else begin
                  bnd_in = bnd_ff + 2'd1;
               end
            end else if (bnd_ff == adt_pkg::BND_ORDER) begin
               state_in = S_BHI_DIV;
            end else begin
               state_in = S_BLO_DIV;
            end
         end
         S_BLO_DIV: begin
            op       = adt_pkg::OP_BLO_DIV;
            state_in = S_BLO_WAIT;
         end
         S_BLO_WAIT: begin
            if (stat.div_done) begin
               op       = adt_pkg::OP_BLO_SAVE;
               state_in = S_BHI_DIV;
            end
         end
         S_BHI_DIV: begin
            op       = adt_pkg::OP_BHI_DIV;
            state_in = S_BHI_WAIT;
         end
         S_BHI_WAIT: begin
            if (stat.div_done) begin
               op = adt_pkg::OP_BHI_SAVE;
               if (bnd_ff == adt_pkg::BND_ORDER) begin
                  state_in = S_PREP;
               end else begin
                  bnd_in   = bnd_ff + 2'd1;
                  state_in = S_BSEL;
               end
            end
         end
         S_PREP: begin
            if (stat.no_dep) begin
               state_in = S_NONE;
            end else begin
               op       = adt_pkg::OP_START;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               op = adt_pkg::OP_EMIT;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_NONE: begin
            if (stat.rsp_free) begin
               op       = adt_pkg::OP_EMIT_NONE;
               state_in = S_IDLE;
            end
         end
         S_CONST: begin
            if (stat.rsp_free) begin
               op       = adt_pkg::OP_EMIT_CONST;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bnd_ff   <= adt_pkg::BND_SRC;
      end else begin
         state_ff <= state_in;
         bnd_ff   <= bnd_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign cmd.op     = op;
   assign cmd.bnd    = bnd_ff;

endmodule

// ----- rtl/core/affine_dependence_tester.sv -----
// Exact GCD dependence test for one pair of affine accesses c*i+d per beat.
// Each extended-Euclid step issues a short-mode run of the shared radix-2
// divider and then the update, for up to about 23 steps; then come three
// short divisions and up to five full-width divisions (issue, the divider
// run, save) to bound the free variable, and one result beat per cycle
// while the output is taken. The next request beat is taken once the
// last result beat of the current pair sits in the output register.
// loop_start and loop_end are written through the csr channel; the user
// must write them only while the block is idle, which the block itself
// does not enforce.
module affine_dependence_tester #(
   parameter int MAX_RESULTS = adt_pkg::MAX_RESULTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // src_coeff, src_const, dst_coeff, dst_const, source stmt, destination stmt
   input  logic [adt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // src_is_store, dst_is_store, same_array
   input  logic [adt_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // source stmt out, destination stmt out, src_index, dst_index
   output logic [adt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // has_dep, dep_kind, truncated
   output logic [adt_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [15:0]                     csr_data
);
   adt_pkg::cmd_type  cmd;
   adt_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   adt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   adt_datapath #(
      .MAX_RESULTS (MAX_RESULTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
